FILE: hw/rtl/scc_pkg.sv
`default_nettype none

package scc_pkg;

	// Field widths
	localparam int COORD_W = 16;
	localparam int DIST_W  = 16;
	localparam int SUM_W   = 28;
	localparam int CNT_W   = 12;
	localparam int IDX_W   = 6;

	// Defaults and limits
	localparam int MAX_FOES_DEF      = 16;
	localparam int MAX_POINTS_DEF    = 1024;
	localparam int COUNT_MAX         = 4095;
	localparam int SMALLEST_REPORTED = 2;
	localparam logic [DIST_W-1:0] JOIN_DISTANCE_RESET = 16'd150;

	typedef enum logic {
		KIND_CENTROID = 1'b0,
		KIND_SUMMARY  = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      point_present;
		logic                      scan_end;
	} scc_in_t;

	typedef struct packed {
		result_kind_t              result_kind;
		logic signed [COORD_W-1:0] centroid_x;
		logic signed [COORD_W-1:0] centroid_y;
		logic [IDX_W-1:0]          cluster_index;
		logic                      last_result;
	} scc_out_t;

	typedef struct packed {
		logic done;
		logic joins;
	} dist_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POINT,
		S_DIST,
		S_ACC,
		S_DIV,
		S_EMIT,
		S_END,
		S_SUMMARY
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scc_dist.sv
`default_nettype none

// Bit-serial Manhattan distance test against a limit.
// First pass subtracts point and anchor LSB first; second pass takes the
// absolute values, adds them and compares with the limit, all one bit a cycle.
module scc_dist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [scc_pkg::COORD_W-1:0] px,
	input  logic signed [scc_pkg::COORD_W-1:0] py,
	input  logic signed [scc_pkg::COORD_W-1:0] ax,
	input  logic signed [scc_pkg::COORD_W-1:0] ay,
	input  logic [scc_pkg::DIST_W-1:0]         limit,
	output scc_pkg::dist_status_t              status
);

	localparam int W        = scc_pkg::COORD_W;
	localparam int SUB_BITS = W + 1;
	localparam int SUM_BITS = W + 2;
	localparam int LAST     = SUB_BITS + SUM_BITS - 1;
	localparam int CW       = $clog2(LAST + 1);

	logic                  active_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;
	logic                  joins_q;

	logic [W-1:0]          xs_q, as_q, ys_q, bs_q;
	logic [scc_pkg::DIST_W-1:0] js_q;
	logic                  lim_max_q;
	logic                  bx_q, by_q;
	logic [SUB_BITS-1:0]   dx_q, dy_q;
	logic                  seenx_q, seeny_q, c_q, gt_q;

	logic sub_phase, last_bit;
	logic dxb, dyb, bx_n, by_n;
	logic axb, ayb, s, c_n, jb, gt_n;

	assign sub_phase = cnt_q < CW'(SUB_BITS);
	assign last_bit  = cnt_q == CW'(LAST);

	// Serial subtract, absolute value, add and compare for the current bit
	always_comb begin
		dxb  = xs_q[0] ^ as_q[0] ^ bx_q;
		bx_n = (~xs_q[0] & as_q[0]) | (~(xs_q[0] ^ as_q[0]) & bx_q);
		dyb  = ys_q[0] ^ bs_q[0] ^ by_q;
		by_n = (~ys_q[0] & bs_q[0]) | (~(ys_q[0] ^ bs_q[0]) & by_q);
		axb  = dx_q[0] ^ (dx_q[SUB_BITS-1] & seenx_q);
		ayb  = dy_q[0] ^ (dy_q[SUB_BITS-1] & seeny_q);
		s    = axb ^ ayb ^ c_q;
		c_n  = (axb & ayb) | (c_q & (axb ^ ayb));
		jb   = js_q[0];
		gt_n = (s & ~jb) | (gt_q & ~(s ^ jb));
	end

	// Sequence the two passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			joins_q  <= 1'b0;
		end else begin
			done_q <= active_q && last_bit;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (last_bit) begin
					active_q <= 1'b0;
					joins_q  <= ~gt_n | lim_max_q;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// Shift operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			xs_q      <= px;
			as_q      <= ax;
			ys_q      <= py;
			bs_q      <= ay;
			js_q      <= limit;
			lim_max_q <= &limit;
			bx_q      <= 1'b0;
			by_q      <= 1'b0;
			seenx_q   <= 1'b0;
			seeny_q   <= 1'b0;
			c_q       <= 1'b0;
			gt_q      <= 1'b0;
		end else if (active_q) begin
			if (sub_phase) begin
				xs_q <= {xs_q[W-1], xs_q[W-1:1]};
				as_q <= {as_q[W-1], as_q[W-1:1]};
				ys_q <= {ys_q[W-1], ys_q[W-1:1]};
				bs_q <= {bs_q[W-1], bs_q[W-1:1]};
				dx_q <= {dxb, dx_q[SUB_BITS-1:1]};
				dy_q <= {dyb, dy_q[SUB_BITS-1:1]};
				bx_q <= bx_n;
				by_q <= by_n;
			end else begin
				dx_q    <= {dx_q[SUB_BITS-1], dx_q[SUB_BITS-1:1]};
				dy_q    <= {dy_q[SUB_BITS-1], dy_q[SUB_BITS-1:1]};
				seenx_q <= seenx_q | dx_q[0];
				seeny_q <= seeny_q | dy_q[0];
				c_q     <= c_n;
				gt_q    <= gt_n;
				js_q    <= {1'b0, js_q[scc_pkg::DIST_W-1:1]};
			end
		end
	end

	assign status.done  = done_q;
	assign status.joins = joins_q;

endmodule

`default_nettype wire

FILE: hw/rtl/scc_acc.sv
`default_nettype none

// Bit-serial coordinate accumulator: the sum rotates once through a
// one-bit adder while the sign-extended addend shifts in beside it.
module scc_acc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               load,
	input  logic                               start,
	input  logic signed [scc_pkg::COORD_W-1:0] value,
	output logic signed [scc_pkg::SUM_W-1:0]   sum,
	output logic                               done
);

	localparam int W    = scc_pkg::COORD_W;
	localparam int SW   = scc_pkg::SUM_W;
	localparam int LAST = SW - 1;
	localparam int CW   = $clog2(SW);

	logic          active_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [SW-1:0] sum_q;
	logic [W-1:0]  add_q;
	logic          c_q;
	logic          s, c_n, last_bit;

	assign last_bit = cnt_q == CW'(LAST);
	assign s        = sum_q[0] ^ add_q[0] ^ c_q;
	assign c_n      = (sum_q[0] & add_q[0]) | (c_q & (sum_q[0] ^ add_q[0]));

	// Sequence the rotation and hold the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			sum_q    <= '0;
		end else begin
			done_q <= active_q && last_bit;
			if (clear) begin
				active_q <= 1'b0;
				sum_q    <= '0;
			end else if (load) begin
				active_q <= 1'b0;
				sum_q    <= {{(SW - W){value[W-1]}}, value};
			end else if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				sum_q <= {s, sum_q[SW-1:1]};
				if (last_bit) begin
					active_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// Shift the addend, sign filling
	always_ff @(posedge clk) begin
		if (start) begin
			add_q <= value;
			c_q   <= 1'b0;
		end else if (active_q) begin
			add_q <= {add_q[W-1], add_q[W-1:1]};
			c_q   <= c_n;
		end
	end

	assign sum  = sum_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/scc_div.sv
`default_nettype none

// Restoring divider, one quotient bit a cycle. Divides the magnitude of
// the sum by the point count and restores the sign: truncation toward zero.
module scc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [scc_pkg::SUM_W-1:0]   dividend,
	input  logic [scc_pkg::CNT_W-1:0]          divisor,
	output logic                               done,
	output logic signed [scc_pkg::COORD_W-1:0] quotient
);

	localparam int SW   = scc_pkg::SUM_W;
	localparam int DW   = scc_pkg::CNT_W;
	localparam int QW   = scc_pkg::COORD_W;
	localparam int LAST = SW - 1;
	localparam int CW   = $clog2(SW);

	logic          active_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          neg_q;
	logic [SW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   trial, diff;
	logic          ge, last_bit;
	logic signed [QW-1:0] q_mag;

	assign last_bit = cnt_q == CW'(LAST);

	// One restoring step
	always_comb begin
		trial = {rem_q, num_q[SW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= active_q && last_bit;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (last_bit) begin
					active_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// Load magnitude, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			num_q <= dividend[SW-1] ? -dividend : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (active_q) begin
			num_q <= {num_q[SW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign q_mag    = num_q[QW-1:0];
	assign quotient = neg_q ? -q_mag : q_mag;
	assign done     = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/scan_point_cluster_centroid_core.sv
// Processing: a point tested against the anchor passes through the serial
// distance unit, then the accumulators when it is summed in or the dividers
// when it closes a cluster that reports; a scan end that reports also divides.
// The block takes a new item only when idle, after the last one is done, and
// result emission waits for a free output slot.
// Reset: scan state clears, join_distance returns to 150, no result pending.
`default_nettype none

module scan_point_cluster_centroid_core #(
	parameter int MAX_FOES   = scc_pkg::MAX_FOES_DEF,
	parameter int MAX_POINTS = scc_pkg::MAX_POINTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  scc_pkg::scc_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output scc_pkg::scc_out_t            out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [scc_pkg::DIST_W-1:0]   cfg_data
);

	localparam int CNW = scc_pkg::CNT_W;
	localparam int IW  = scc_pkg::IDX_W;
	localparam int CLUSTER_CAP = (MAX_POINTS > scc_pkg::COUNT_MAX) ?
		scc_pkg::COUNT_MAX : MAX_POINTS;
	localparam logic [CNW-1:0] CAP       = CNW'(CLUSTER_CAP);
	localparam logic [CNW-1:0] MIN_CNT   = CNW'(scc_pkg::SMALLEST_REPORTED);
	localparam logic [IW-1:0]  FOE_LIMIT = IW'(MAX_FOES - 1);

	scc_pkg::state_t   state_q, state_n;
	scc_pkg::scc_in_t  in_q;
	scc_pkg::scc_out_t out_q;
	logic              out_valid_q;

	logic signed [scc_pkg::COORD_W-1:0] anchor_x_q, anchor_y_q;
	logic [CNW-1:0]             count_q;
	logic [IW-1:0]              reported_q;
	logic                       open_q;
	logic                       closing_end_q;
	logic [scc_pkg::DIST_W-1:0] jd_q;

	scc_pkg::dist_status_t dist_st;
	logic signed [scc_pkg::SUM_W-1:0]   sum_x, sum_y;
	logic signed [scc_pkg::COORD_W-1:0] qx, qy;
	logic acc_done_x, acc_done_y, div_done_x, div_done_y;
	logic acc_done, div_done;

	logic accept, slot_free, reportable, cap_ok;
	logic dist_start, acc_start, div_start, begin_cluster, count_inc;
	logic emit_centroid, emit_summary;

	assign accept     = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	assign reportable = open_q && (count_q > MIN_CNT) && (reported_q < FOE_LIMIT);
	assign cap_ok     = count_q < CAP;
	assign acc_done   = acc_done_x && acc_done_y;
	assign div_done   = div_done_x && div_done_y;
	assign cfg_ready  = 1'b1;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			scc_pkg::S_IDLE: begin
				if (accept) state_n = scc_pkg::S_POINT;
			end
			scc_pkg::S_POINT: begin
				if (in_q.point_present && open_q) state_n = scc_pkg::S_DIST;
				else state_n = scc_pkg::S_END;
			end
			scc_pkg::S_DIST: begin
				if (dist_st.done) begin
					if (dist_st.joins) begin
						state_n = cap_ok ? scc_pkg::S_ACC : scc_pkg::S_END;
					end else begin
						state_n = reportable ? scc_pkg::S_DIV : scc_pkg::S_END;
					end
				end
			end
			scc_pkg::S_ACC: begin
				if (acc_done) state_n = scc_pkg::S_END;
			end
			scc_pkg::S_DIV: begin
				if (div_done) state_n = scc_pkg::S_EMIT;
			end
			scc_pkg::S_EMIT: begin
				if (slot_free) begin
					state_n = closing_end_q ? scc_pkg::S_SUMMARY : scc_pkg::S_END;
				end
			end
			scc_pkg::S_END: begin
				if (in_q.scan_end) begin
					state_n = reportable ? scc_pkg::S_DIV : scc_pkg::S_SUMMARY;
				end else begin
					state_n = scc_pkg::S_IDLE;
				end
			end
			scc_pkg::S_SUMMARY: begin
				if (slot_free) state_n = scc_pkg::S_IDLE;
			end
			default: state_n = scc_pkg::S_IDLE;
		endcase
	end

	// Control strobes
	always_comb begin
		in_ready      = 1'b0;
		dist_start    = 1'b0;
		acc_start     = 1'b0;
		div_start     = 1'b0;
		begin_cluster = 1'b0;
		count_inc     = 1'b0;
		emit_centroid = 1'b0;
		emit_summary  = 1'b0;
		case (state_q)
			scc_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			scc_pkg::S_POINT: begin
				if (in_q.point_present && open_q) dist_start = 1'b1;
				else if (in_q.point_present) begin_cluster = 1'b1;
			end
			scc_pkg::S_DIST: begin
				if (dist_st.done) begin
					if (dist_st.joins) acc_start = cap_ok;
					else if (reportable) div_start = 1'b1;
					else begin_cluster = 1'b1;
				end
			end
			scc_pkg::S_ACC: begin
				count_inc = acc_done;
			end
			scc_pkg::S_EMIT: begin
				if (slot_free) begin
					emit_centroid = 1'b1;
					begin_cluster = !closing_end_q;
				end
			end
			scc_pkg::S_END: begin
				div_start = in_q.scan_end && reportable;
			end
			scc_pkg::S_SUMMARY: begin
				emit_summary = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Hold control state and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= scc_pkg::S_IDLE;
			out_valid_q   <= 1'b0;
			anchor_x_q    <= '0;
			anchor_y_q    <= '0;
			count_q       <= '0;
			reported_q    <= '0;
			open_q        <= 1'b0;
			closing_end_q <= 1'b0;
			jd_q          <= scc_pkg::JOIN_DISTANCE_RESET;
		end else begin
			state_q <= state_n;
			if (cfg_valid) jd_q <= cfg_data;
			if (div_start) closing_end_q <= (state_q == scc_pkg::S_END);
			if (count_inc) count_q <= count_q + CNW'(1);
			if (emit_centroid) begin
				reported_q <= reported_q + IW'(1);
				// Close the cluster unless the point reopens one below
				if (closing_end_q) open_q <= 1'b0;
			end
			if (begin_cluster) begin
				anchor_x_q <= in_q.point_x;
				anchor_y_q <= in_q.point_y;
				count_q    <= CNW'(1);
				open_q     <= 1'b1;
			end
			if (emit_summary) begin
				anchor_x_q <= '0;
				anchor_y_q <= '0;
				count_q    <= '0;
				reported_q <= '0;
				open_q     <= 1'b0;
			end
			// Advance the output register
			if (emit_centroid || emit_summary) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Capture the input transaction and load the result
	always_ff @(posedge clk) begin
		if (accept) in_q <= in_data;
		if (emit_centroid) begin
			out_q.result_kind   <= scc_pkg::KIND_CENTROID;
			out_q.centroid_x    <= qx;
			out_q.centroid_y    <= qy;
			out_q.cluster_index <= reported_q;
			out_q.last_result   <= ~in_q.scan_end;
		end else if (emit_summary) begin
			out_q.result_kind   <= scc_pkg::KIND_SUMMARY;
			out_q.centroid_x    <= '0;
			out_q.centroid_y    <= '0;
			out_q.cluster_index <= reported_q;
			out_q.last_result   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	scc_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.px     (in_q.point_x),
		.py     (in_q.point_y),
		.ax     (anchor_x_q),
		.ay     (anchor_y_q),
		.limit  (jd_q),
		.status (dist_st)
	);

	scc_acc u_acc_x (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (emit_summary),
		.load   (begin_cluster),
		.start  (acc_start),
		.value  (in_q.point_x),
		.sum    (sum_x),
		.done   (acc_done_x)
	);

	scc_acc u_acc_y (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (emit_summary),
		.load   (begin_cluster),
		.start  (acc_start),
		.value  (in_q.point_y),
		.sum    (sum_y),
		.done   (acc_done_y)
	);

	scc_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_x),
		.divisor  (count_q),
		.done     (div_done_x),
		.quotient (qx)
	);

	scc_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_y),
		.divisor  (count_q),
		.done     (div_done_y),
		.quotient (qy)
	);

endmodule

`default_nettype wire

FILE: bench/tb_scan_point_cluster_centroid_core.sv
`timescale 1ns / 1ps

module tb_scan_point_cluster_centroid_core;
	import scc_pkg::*;

	localparam int CLUSTER_CAP   = (MAX_POINTS_DEF > COUNT_MAX) ? COUNT_MAX : MAX_POINTS_DEF;
	localparam int REPORT_LIMIT  = MAX_FOES_DEF - 1;
	localparam int SPAN_SAT      = 65535;
	localparam int SETTLE_CYCLES = 250;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int MAX_REPORTS   = 100;
	localparam int MAX_IDLE      = 19;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	scc_in_t             in_data;
	logic                out_valid;
	logic                out_ready;
	scc_out_t            out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [DIST_W-1:0]   cfg_data;

	scan_point_cluster_centroid_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Predicted block state
	logic [DIST_W-1:0]         join_dist;
	logic signed [COORD_W-1:0] anchor_px;
	logic signed [COORD_W-1:0] anchor_py;
	logic signed [SUM_W-1:0]   sum_px;
	logic signed [SUM_W-1:0]   sum_py;
	logic [CNT_W-1:0]          cluster_pts;
	logic [IDX_W-1:0]          centroids_sent;
	logic                      cluster_live;

	// Centroids and summaries still owed by the block, oldest first
	scc_out_t pending_results[$];

	bit src_jitter;
	bit sink_jitter;
	int hold_off       = 0;
	int sink_wait      = 0;
	int err_count      = 0;
	int cycle_count    = 0;
	int items_sent     = 0;
	int centroids_seen = 0;
	int summaries_seen = 0;
	int settings_used  = 0;

	// Free-running clock, 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, pending_results.size());
			$display("tb_scan_point_cluster_centroid_core: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_scan();
		anchor_px      = '0;
		anchor_py      = '0;
		sum_px         = '0;
		sum_py         = '0;
		cluster_pts    = '0;
		centroids_sent = '0;
		cluster_live   = 1'b0;
	endfunction

	function automatic void open_cluster(logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y);
		anchor_px    = x;
		anchor_py    = y;
		sum_px       = x;
		sum_py       = y;
		cluster_pts  = 1;
		cluster_live = 1'b1;
	endfunction

	// Close the open cluster; return 1 when it yields a centroid
	function automatic bit close_cluster(output scc_out_t res);
		int sx;
		int sy;
		bit reports;
		res = '0;
		reports = cluster_live && cluster_pts > SMALLEST_REPORTED &&
			centroids_sent < REPORT_LIMIT;
		if (reports) begin
			sx = sum_px;
			sy = sum_py;
			sx = sx / int'(cluster_pts);
			sy = sy / int'(cluster_pts);
			res.result_kind   = KIND_CENTROID;
			res.centroid_x    = sx[COORD_W-1:0];
			res.centroid_y    = sy[COORD_W-1:0];
			res.cluster_index = centroids_sent;
			centroids_sent    = centroids_sent + 1'b1;
		end
		cluster_live = 1'b0;
		return reports;
	endfunction

	function automatic void predict_item(scc_in_t pt);
		scc_out_t produced[$];
		scc_out_t res;
		int dx;
		int dy;
		int span;
		if (pt.point_present) begin
			if (!cluster_live) begin
				open_cluster(pt.point_x, pt.point_y);
			end else begin
				dx = int'(pt.point_x) - int'(anchor_px);
				dy = int'(pt.point_y) - int'(anchor_py);
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				span = dx + dy;
				if (span > SPAN_SAT) span = SPAN_SAT;
				if (span <= int'(join_dist)) begin
					// drop points once the cluster is full
					if (cluster_pts < CLUSTER_CAP) begin
						sum_px      = sum_px + pt.point_x;
						sum_py      = sum_py + pt.point_y;
						cluster_pts = cluster_pts + 1'b1;
					end
				end else begin
					if (close_cluster(res)) produced.push_back(res);
					open_cluster(pt.point_x, pt.point_y);
				end
			end
		end
		if (pt.scan_end) begin
			if (close_cluster(res)) produced.push_back(res);
			res = '0;
			res.result_kind   = KIND_SUMMARY;
			res.cluster_index = centroids_sent;
			produced.push_back(res);
			clear_scan();
		end
		if (produced.size() > 0) produced[produced.size() - 1].last_result = 1'b1;
		foreach (produced[i]) pending_results.push_back(produced[i]);
	endfunction

	// ---------------------------------------------------------------- result side

	// Draw a stall per result; a long hold-off overrides it
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off = hold_off - 1;
			out_ready <= 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait = sink_wait - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void check_field(string name, logic signed [16:0] want,
			logic signed [16:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		scc_out_t want;
		if (arst_n && out_valid && out_ready) begin
			sink_wait = sink_jitter ? $urandom_range(0, MAX_IDLE) : 0;
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display({"%0t: unexpected result, expected none, ",
						"actual kind %0d x %0d y %0d idx %0d last %0d"},
						$time, out_data.result_kind, out_data.centroid_x, out_data.centroid_y,
						out_data.cluster_index, out_data.last_result);
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", want.result_kind, out_data.result_kind);
				check_field("centroid_x", want.centroid_x, out_data.centroid_x);
				check_field("centroid_y", want.centroid_y, out_data.centroid_y);
				check_field("cluster_index", want.cluster_index, out_data.cluster_index);
				check_field("last_result", want.last_result, out_data.last_result);
				if (want.result_kind == KIND_SUMMARY) summaries_seen++;
				else centroids_seen++;
			end
		end
	end

	// ---------------------------------------------------------------- input side

	// Offer one scan item and hold it until the block takes it
	task automatic send_item(input int x, input int y, input logic present,
			input logic closes_scan);
		scc_in_t pt;
		int gap;
		pt.point_x       = x[COORD_W-1:0];
		pt.point_y       = y[COORD_W-1:0];
		pt.point_present = present;
		pt.scan_end      = closes_scan;
		gap = src_jitter ? $urandom_range(0, MAX_IDLE) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= pt;
		do @(posedge clk); while (!in_ready);
		predict_item(pt);
		if (present || closes_scan) items_sent++;
	endtask

	// Stop offering and let every owed result and trailing work finish
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_join_distance(input logic [DIST_W-1:0] value);
		drain_block();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		join_dist = value;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int clip_coord(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Pick a point within budget of the anchor, or exactly at budget
	function automatic void near_point(input int ax, input int ay, input int budget,
			input bit exact, output int nx, output int ny);
		int mx;
		int my;
		mx = $urandom_range(0, budget);
		my = exact ? budget - mx : $urandom_range(0, budget - mx);
		if ($urandom_range(0, 1)) mx = -mx;
		if ($urandom_range(0, 1)) my = -my;
		nx = clip_coord(ax + mx);
		ny = clip_coord(ay + my);
	endfunction

	// One well-formed scan: several clusters of random size, then an end item
	task automatic random_scan();
		int ax;
		int ay;
		int nx;
		int ny;
		int clusters;
		int extra;
		ax = rand_coord();
		ay = rand_coord();
		clusters = $urandom_range(1, 6);
		for (int c = 0; c < clusters; c++) begin
			if (c > 0 && $urandom_range(0, 3) == 0 && join_dist != 16'hFFFF) begin
				near_point(ax, ay, int'(join_dist) + 1, 1'b1, ax, ay);
			end else begin
				ax = rand_coord();
				ay = rand_coord();
			end
			send_item(ax, ay, 1'b1, 1'b0);
			extra = $urandom_range(0, 5);
			repeat (extra) begin
				if ($urandom_range(0, 9) == 0) send_item(rand_coord(), rand_coord(), 1'b0, 1'b0);
				near_point(ax, ay, int'(join_dist), $urandom_range(0, 3) == 0, nx, ny);
				send_item(nx, ny, 1'b1, 1'b0);
			end
		end
		case ($urandom_range(0, 2))
			0: begin
				send_item(rand_coord(), rand_coord(), 1'b0, 1'b1);
			end
			1: begin
				near_point(ax, ay, int'(join_dist), 1'b0, nx, ny);
				send_item(nx, ny, 1'b1, 1'b1);
			end
			default: begin
				send_item(rand_coord(), rand_coord(), 1'b1, 1'b1);
			end
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	// Idle item, empty scan, extreme corners, small clusters, rounding toward zero
	task automatic test_directed_scans();
		send_item(0, 0, 1'b0, 1'b0);
		send_item(0, 0, 1'b0, 1'b1);
		send_item(-32768, -32768, 1'b1, 1'b0);
		send_item(-32768, -32768, 1'b1, 1'b0);
		send_item(-32767, -32767, 1'b1, 1'b0);
		send_item(32767, 32767, 1'b1, 1'b0);
		send_item(32767, 32766, 1'b1, 1'b0);
		send_item(32766, 32767, 1'b1, 1'b1);
		send_item(100, 100, 1'b1, 1'b0);
		send_item(101, 100, 1'b1, 1'b0);
		send_item(-5000, 0, 1'b1, 1'b0);
		send_item(-5001, 0, 1'b1, 1'b0);
		send_item(-4999, 1, 1'b1, 1'b0);
		send_item(0, 0, 1'b0, 1'b1);
		send_item(-1, 1, 1'b1, 1'b0);
		send_item(-1, 1, 1'b1, 1'b0);
		send_item(1, -1, 1'b1, 1'b0);
		send_item(5000, 5000, 1'b1, 1'b1);
	endtask

	// Points exactly at and one past the join distance; leave a cluster open
	task automatic test_join_boundary();
		send_item(0, 0, 1'b1, 1'b0);
		send_item(100, 50, 1'b1, 1'b0);
		send_item(-100, -50, 1'b1, 1'b0);
		send_item(100, 51, 1'b1, 1'b0);
	endtask

	// Tighten the join distance to zero while the scan is still open
	task automatic test_midscan_register();
		write_join_distance(16'd0);
		send_item(100, 51, 1'b1, 1'b0);
		send_item(100, 51, 1'b1, 1'b0);
		send_item(100, 52, 1'b1, 1'b0);
		send_item(0, 0, 1'b0, 1'b1);
	endtask

	// Corner-to-corner distance saturates and joins only at the widest setting
	task automatic test_distance_saturation();
		write_join_distance(16'hFFFF);
		send_item(-32768, -32768, 1'b1, 1'b0);
		send_item(32767, 32767, 1'b1, 1'b0);
		send_item(32767, -32768, 1'b1, 1'b0);
		send_item(-32768, 32767, 1'b1, 1'b0);
		send_item(0, 0, 1'b0, 1'b1);
		write_join_distance(16'hFFFE);
		send_item(-32768, -32768, 1'b1, 1'b0);
		send_item(32767, 32767, 1'b1, 1'b1);
		write_join_distance(JOIN_DISTANCE_RESET);
	endtask

	// One cluster more than the per-scan report limit
	task automatic test_report_limit();
		for (int c = 0; c < REPORT_LIMIT + 1; c++) begin
			repeat (3) send_item(c * 3000 - 24000, c * 17, 1'b1, 1'b0);
		end
		send_item(0, 0, 1'b0, 1'b1);
	endtask

	// Block the result side for a long stretch while items keep coming
	task automatic test_output_backpressure();
		src_jitter = 1'b0;
		hold_off   = 3000;
		for (int s = 0; s < 2; s++) begin
			for (int c = 0; c < 6; c++) begin
				repeat (3) send_item(c * 4000 - 12000, s * 500, 1'b1, 1'b0);
			end
			send_item(0, 0, 1'b0, 1'b1);
		end
		drain_block();
		src_jitter = 1'b1;
	endtask

	// Random scans under several join distances and idle patterns
	task automatic test_random_scans();
		logic [DIST_W-1:0] settings [5];
		int phase_target;
		settings[0] = 16'd0;
		settings[1] = 16'hFFFF;
		settings[2] = JOIN_DISTANCE_RESET;
		settings[3] = $urandom_range(0, 65535);
		settings[4] = $urandom_range(1, 40);
		for (int p = 0; p < 5; p++) begin
			write_join_distance(settings[p]);
			src_jitter  = (p != 2 && p != 3);
			sink_jitter = (p != 2 && p != 1);
			phase_target = items_sent + 50;
			while (items_sent < phase_target) begin
				if ($urandom_range(0, 6) == 0)
					send_item(rand_coord(), rand_coord(), $urandom_range(0, 1),
						$urandom_range(0, 4) == 0);
				else
					random_scan();
			end
		end
		src_jitter  = 1'b1;
		sink_jitter = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		src_jitter  = 1'b1;
		sink_jitter = 1'b1;
		join_dist   = JOIN_DISTANCE_RESET;
		clear_scan();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_scans();
		test_join_boundary();
		test_midscan_register();
		test_distance_saturation();
		test_report_limit();
		test_output_backpressure();
		test_random_scans();
		drain_block();

		$display("Sent %0d scan items under %0d join-distance writes, incl. empty,", items_sent,
			settings_used);
		$display("saturated, over-limit and stalled scans; checked %0d centroids, %0d summaries.",
			centroids_seen, summaries_seen);
		if (err_count == 0) begin
			$display("tb_scan_point_cluster_centroid_core: clean");
		end else begin
			$display("tb_scan_point_cluster_centroid_core: errors");
		end
		$finish;
	end

endmodule
